// ----- hdl/ilp_pkg.sv -----
// Shared types and character constants for the integer literal parser.
// No dependencies; used by ilp_lexer and integer_literal_parser_unit.
package ilp_pkg;

   localparam int SymbolWidth = 8;
   localparam int ValueWidth  = 64;
   localparam int RadixWidth  = 2;

   localparam logic [SymbolWidth-1:0] CH_NUL   = 8'h00;
   localparam logic [SymbolWidth-1:0] CH_SPACE = 8'h20;
   localparam logic [SymbolWidth-1:0] CH_MINUS = 8'h2D;
   localparam logic [SymbolWidth-1:0] CH_ZERO  = 8'h30;
   localparam logic [SymbolWidth-1:0] CH_ONE   = 8'h31;
   localparam logic [SymbolWidth-1:0] CH_NINE  = 8'h39;
   localparam logic [SymbolWidth-1:0] CH_UP_A  = 8'h41;
   localparam logic [SymbolWidth-1:0] CH_UP_B  = 8'h42;
   localparam logic [SymbolWidth-1:0] CH_UP_F  = 8'h46;
   localparam logic [SymbolWidth-1:0] CH_UP_X  = 8'h58;
   localparam logic [SymbolWidth-1:0] CH_LO_A  = 8'h61;
   localparam logic [SymbolWidth-1:0] CH_LO_B  = 8'h62;
   localparam logic [SymbolWidth-1:0] CH_LO_F  = 8'h66;
   localparam logic [SymbolWidth-1:0] CH_LO_X  = 8'h78;

   localparam logic [ValueWidth-1:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ValueWidth-1:0] LIM_NEG = 64'h8000_0000_0000_0000;

   localparam logic [RadixWidth-1:0] RADIX_DEC = 2'd0;
   localparam logic [RadixWidth-1:0] RADIX_HEX = 2'd1;
   localparam logic [RadixWidth-1:0] RADIX_BIN = 2'd2;

   typedef struct packed {
      logic                          accepted;
      logic signed [ValueWidth-1:0]  value;
      logic [RadixWidth-1:0]         radix;
      logic                          saturated;
   } ilp_result_type;

endpackage

// ----- hdl/ilp_lexer.sv -----
// Character-by-character lexer state and its registered update: phase machines,
// saturating accumulators and the result formed on the closing word.
// Depends on ilp_pkg.
module ilp_lexer import ilp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [SymbolWidth-1:0] symbol,
   input  logic                   last,
   output ilp_result_type         result
);

   typedef enum logic [3:0] {
      ST_START, ST_SIGN, ST_ZERO, ST_DEC, ST_HEX0, ST_HEX, ST_DEC_OK, ST_HEX_OK, ST_BAD
   } phase_type;

   typedef enum logic [1:0] {
      BP_NONE, BP_SOME, BP_MATCH, BP_FAIL
   } bin_phase_type;

   phase_type               phase_ff, phase_in, phase_fin;
   bin_phase_type           bphase_ff, bphase_in;
   logic [ValueWidth-1:0]   acc_ff, acc_in;
   logic [ValueWidth-1:0]   bacc_ff, bacc_in;
   logic                    neg_ff, neg_in;
   logic                    ovf_main_ff, ovf_main_in;
   logic                    ovf_bin_ff, ovf_bin_in;

   logic                    is_dec, is_bin, is_hex, is_term;
   logic [3:0]              hex_digit;
   logic [ValueWidth-1:0]   dec_lim;
   logic [ValueWidth+3:0]   dec_prod, hex_prod;
   logic [ValueWidth:0]     bin_prod;
   logic                    dec_ovf, hex_ovf, bin_ovf;
   logic [ValueWidth-1:0]   dec_next, hex_next;

   always_comb begin
      is_dec  = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
      is_bin  = (symbol == CH_ZERO) || (symbol == CH_ONE);
      is_term = (symbol == CH_NUL) || (symbol == CH_SPACE);
      is_hex  = 1'b1;
      hex_digit = 4'd0;
      if (is_dec) begin
         hex_digit = 4'(symbol - CH_ZERO);
      end else if ((symbol >= CH_LO_A) && (symbol <= CH_LO_F)) begin
         hex_digit = 4'(symbol - CH_LO_A + 8'd10);
      end else if ((symbol >= CH_UP_A) && (symbol <= CH_UP_F)) begin
         hex_digit = 4'(symbol - CH_UP_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   // Each accumulator step is acc * base + digit, compared against the limit;
   // the product is kept wide so that the compare sees the true value.
   always_comb begin
      dec_lim  = neg_ff ? LIM_NEG : LIM_POS;
      dec_prod = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + (ValueWidth+4)'(hex_digit);
      hex_prod = ({4'd0, acc_ff} << 4) + (ValueWidth+4)'(hex_digit);
      bin_prod = ({1'b0, bacc_ff} << 1) + (ValueWidth+1)'(symbol[0]);
      dec_ovf  = dec_prod > {4'd0, dec_lim};
      hex_ovf  = hex_prod > {4'd0, LIM_POS};
      bin_ovf  = bin_prod > {1'b0, LIM_POS};
      dec_next = dec_ovf ? dec_lim : dec_prod[ValueWidth-1:0];
      hex_next = hex_ovf ? LIM_POS : hex_prod[ValueWidth-1:0];
   end

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      ovf_main_in = ovf_main_ff;
      case (phase_ff)
         ST_START: begin
            if (symbol == CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = ST_SIGN;
            end else if (symbol == CH_ZERO) begin
               phase_in = ST_ZERO;
            end else if (is_dec) begin
               acc_in      = dec_next;
               ovf_main_in = ovf_main_ff | dec_ovf;
               phase_in    = ST_DEC;
            end else begin
               phase_in = is_term ? ST_DEC_OK : ST_BAD;
            end
         end
         ST_SIGN, ST_DEC: begin
            if (is_dec) begin
               acc_in      = dec_next;
               ovf_main_in = ovf_main_ff | dec_ovf;
               phase_in    = ST_DEC;
            end else begin
               phase_in = is_term ? ST_DEC_OK : ST_BAD;
            end
         end
         ST_ZERO: begin
            if ((symbol == CH_LO_X) || (symbol == CH_UP_X)) begin
               phase_in = ST_HEX0;
            end else if (is_dec) begin
               acc_in      = dec_next;
               ovf_main_in = ovf_main_ff | dec_ovf;
               phase_in    = ST_DEC;
            end else begin
               phase_in = is_term ? ST_DEC_OK : ST_BAD;
            end
         end
         ST_HEX0, ST_HEX: begin
            if (is_hex) begin
               acc_in      = hex_next;
               ovf_main_in = ovf_main_ff | hex_ovf;
               phase_in    = ST_HEX;
            end else if (is_term && (phase_ff == ST_HEX)) begin
               phase_in = ST_HEX_OK;
            end else begin
               phase_in = ST_BAD;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_comb begin
      bphase_in  = bphase_ff;
      bacc_in    = bacc_ff;
      ovf_bin_in = ovf_bin_ff;
      if ((bphase_ff == BP_NONE) || (bphase_ff == BP_SOME)) begin
         if (is_bin) begin
            bacc_in    = bin_ovf ? LIM_POS : bin_prod[ValueWidth-1:0];
            ovf_bin_in = ovf_bin_ff | bin_ovf;
            bphase_in  = BP_SOME;
         end else if (((symbol == CH_LO_B) || (symbol == CH_UP_B)) && (bphase_ff == BP_SOME)) begin
            bphase_in = BP_MATCH;
         end else begin
            bphase_in = BP_FAIL;
         end
      end
   end

   // The end of the string closes the decimal and hex forms.
   always_comb begin
      case (phase_in)
         ST_START, ST_SIGN, ST_ZERO, ST_DEC: phase_fin = ST_DEC_OK;
         ST_HEX:                             phase_fin = ST_HEX_OK;
         default:                            phase_fin = phase_in;
      endcase
      result = '0;
      if (phase_fin == ST_DEC_OK) begin
         result.accepted  = 1'b1;
         result.value     = neg_in ? ValueWidth'(64'd0 - acc_in) : acc_in;
         result.radix     = RADIX_DEC;
         result.saturated = ovf_main_in;
      end else if (phase_fin == ST_HEX_OK) begin
         result.accepted  = 1'b1;
         result.value     = acc_in;
         result.radix     = RADIX_HEX;
         result.saturated = ovf_main_in;
      end else if (bphase_in == BP_MATCH) begin
         result.accepted  = 1'b1;
         result.value     = bacc_in;
         result.radix     = RADIX_BIN;
         result.saturated = ovf_bin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && last)) begin
         phase_ff    <= ST_START;
         bphase_ff   <= BP_NONE;
         acc_ff      <= '0;
         bacc_ff     <= '0;
         neg_ff      <= 1'b0;
         ovf_main_ff <= 1'b0;
         ovf_bin_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         bphase_ff   <= bphase_in;
         acc_ff      <= acc_in;
         bacc_ff     <= bacc_in;
         neg_ff      <= neg_in;
         ovf_main_ff <= ovf_main_in;
         ovf_bin_ff  <= ovf_bin_in;
      end
   end

endmodule

// ----- hdl/integer_literal_parser_unit.sv -----
// Top level of the integer literal parser: input word register, lexer stage
// and result register with stream handshakes. Depends on ilp_pkg and ilp_lexer.
//
// The unit takes one character word per cycle unless stalled and returns one result word on
// the character marked by tlast: whether the literal is a valid decimal
// (optional leading minus), hex (0x or 0X prefix) or binary (0/1 digits then b
// or B) integer, its 64-bit value saturated to the signed limits, the radix and
// a saturation flag. A character is held in the input register while the lexer
// updates from it; when a closing character leaves that register, its result is
// loaded into the result register and offered from there. The unit sustains one
// character per cycle while no closing character is stalled; the lexer state is
// registered between consecutive characters. A closing character stays in the input
// register, stalling the input, while the previous result is still waiting.
module integer_literal_parser_unit import ilp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,   // last character of the literal
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [0] accepted, [64:1] value, [65] saturated, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] radix
);

   logic                   in_valid_ff;
   logic [SymbolWidth-1:0] in_symbol_ff;
   logic                   in_last_ff;
   logic                   advance;
   logic                   rsp_valid_ff;
   ilp_result_type         rsp_data_ff;
   ilp_result_type         step_result;

   // A character leaves the input register unless it closes a literal while
   // the previous result is still waiting.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_symbol_ff <= req_tdata[SymbolWidth-1:0];
         in_last_ff   <= req_tlast;
      end
   end

   ilp_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .symbol  (in_symbol_ff),
      .last    (in_last_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.saturated, rsp_data_ff.value, rsp_data_ff.accepted};
   assign rsp_tuser  = rsp_data_ff.radix;

`ifndef SYNTH
   a_reject_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> (rsp_tdata[71:1] == '0) && (rsp_tuser == RADIX_DEC))
      else $error("rejected literal carries a nonzero value, flag or radix");

   a_radix_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == RADIX_DEC) || (rsp_tuser == RADIX_HEX)
                     || (rsp_tuser == RADIX_BIN))
      else $error("result radix code out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_symbol_ff) && $stable(in_last_ff))
      else $error("stalled input word was lost or changed");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_valid_ff)
      else $error("closing word did not load a result");
`endif

endmodule
